// File: rtl/pce_pkg.sv
// shared constants and types for the path cycle eraser
package pce_pkg;
	localparam int MAX_LEN   = 64;
	localparam int MAX_NODES = 4096;
	localparam int NODE_W    = 12;
	localparam int POS_W     = $clog2(MAX_LEN);
	localparam int CNT_W     = $clog2(MAX_LEN + 1);
	localparam int SLOT_W    = $clog2(MAX_NODES);
	localparam int CLR_W     = $clog2(MAX_NODES + 1);

	typedef struct packed {
		logic             seen;
		logic [POS_W-1:0] first;
		logic [POS_W-1:0] latest;
	} slot_t;

	typedef enum logic [7:0] {
		ST_CLR   = 8'b0000_0001,
		ST_IDLE  = 8'b0000_0010,
		ST_LD_WR = 8'b0000_0100,
		ST_W_RB  = 8'b0000_1000,
		ST_W_RS  = 8'b0001_0000,
		ST_W_EV  = 8'b0010_0000,
		ST_W_END = 8'b0100_0000,
		ST_W_APP = 8'b1000_0000
	} state_t;
endpackage

// File: rtl/path_cycle_eraser_top.sv
// top level of the path cycle eraser: path buffer, slot table and erasure walk
//
// channel  direction  handshake          payload
// in       request    in_valid/in_stall  node, last
// out      result     out_valid/out_stall kept_node, end_of_path, overflow
//
// loading reads each node's slot table entry, then writes it back
// the erasure walk goes through each stored node (buffer read, slot table read,
// decide), then closes the path (ST_W_END, then ST_W_APP if needed); output stalls hold the walk
// after reset a clearing pass writes every slot table entry, during which
// in_stall is high
// in_stall stays high from a path's final request until its last result is loaded
module path_cycle_eraser_top
	import pce_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [NODE_W-1:0] node,
	input  logic              last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [NODE_W-1:0] kept_node,
	output logic              end_of_path,
	output logic              overflow
);
	state_t state_q;

	logic [NODE_W-1:0] path_mem [MAX_LEN];
	slot_t             slot_mem [MAX_NODES];

	logic [NODE_W-1:0] buf_rd_q;
	slot_t             slot_rd_q;
	logic [SLOT_W-1:0] slot_raddr;
	logic              slot_we;
	logic [SLOT_W-1:0] slot_waddr;
	slot_t             slot_wdata;

	logic [CLR_W-1:0]  clr_q;
	logic [CNT_W-1:0]  fill_q;
	logic [CNT_W-1:0]  idx_q;
	logic [CNT_W-1:0]  reach_q;
	logic [CNT_W-1:0]  reach_cand;
	logic [POS_W-1:0]  pos_q;
	logic [SLOT_W-1:0] slot_q;
	logic [NODE_W-1:0] node_q;
	logic [NODE_W-1:0] final_q;
	logic [NODE_W-1:0] pend_q;
	logic              pend_v_q;
	logic              last_q;
	logic              cut_q;

	logic              accept;
	logic              out_free;
	logic              push;
	logic [NODE_W-1:0] push_node;
	logic              push_eop;
	logic              keep;

	assign in_stall = (state_q != ST_IDLE);
	assign accept   = in_valid && !in_stall;
	assign out_free = !out_valid || !out_stall;
	assign keep     = (reach_q <= idx_q);
	assign reach_cand = CNT_W'(slot_rd_q.latest) + CNT_W'(1);

	// memories
	always_ff @(posedge clk) begin
		if (accept && fill_q != CNT_W'(MAX_LEN)) begin
			path_mem[fill_q[POS_W-1:0]] <= node;
		end
		buf_rd_q <= path_mem[idx_q[POS_W-1:0]];
	end

	always_comb begin
		slot_raddr = node[SLOT_W-1:0];
		if (state_q == ST_W_RS) begin
			slot_raddr = buf_rd_q[SLOT_W-1:0];
		end else if (state_q == ST_W_EV) begin
			// hold the entry while the result side stalls
			slot_raddr = slot_q;
		end
		slot_we    = 1'b0;
		slot_waddr = slot_q;
		slot_wdata = slot_rd_q;
		case (state_q)
			ST_CLR: begin
				slot_we    = 1'b1;
				slot_waddr = clr_q[SLOT_W-1:0];
				slot_wdata = '0;
			end
			ST_LD_WR: begin
				slot_we           = 1'b1;
				slot_wdata.seen   = 1'b1;
				slot_wdata.first  = slot_rd_q.seen ? slot_rd_q.first : pos_q;
				slot_wdata.latest = pos_q;
			end
			ST_W_EV: begin
				// positions stay, only the seen bit goes for the next path
				slot_we         = out_free;
				slot_wdata.seen = 1'b0;
			end
			default: begin
				slot_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (slot_we) begin
			slot_mem[slot_waddr] <= slot_wdata;
		end
		slot_rd_q <= slot_mem[slot_raddr];
	end

	// result selection
	always_comb begin
		push      = 1'b0;
		push_node = pend_q;
		push_eop  = 1'b0;
		case (state_q)
			ST_W_EV: begin
				push = out_free && keep && pend_v_q;
			end
			ST_W_END: begin
				push     = out_free;
				push_eop = (final_q == pend_q);
			end
			ST_W_APP: begin
				push      = out_free;
				push_node = final_q;
				push_eop  = 1'b1;
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (push) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			kept_node   <= push_node;
			end_of_path <= push_eop;
			overflow    <= cut_q;
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLR;
			clr_q    <= '0;
			fill_q   <= '0;
			idx_q    <= '0;
			reach_q  <= '0;
			pend_v_q <= 1'b0;
			cut_q    <= 1'b0;
			last_q   <= 1'b0;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + CLR_W'(1);
					if (clr_q == CLR_W'(MAX_NODES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						last_q <= last;
						if (fill_q != CNT_W'(MAX_LEN)) begin
							fill_q  <= fill_q + CNT_W'(1);
							state_q <= ST_LD_WR;
						end else begin
							// path cut, extra nodes dropped
							cut_q <= 1'b1;
							if (last) begin
								idx_q    <= '0;
								reach_q  <= '0;
								pend_v_q <= 1'b0;
								state_q  <= ST_W_RB;
							end
						end
					end
				end
				ST_LD_WR: begin
					if (last_q) begin
						idx_q    <= '0;
						reach_q  <= '0;
						pend_v_q <= 1'b0;
						state_q  <= ST_W_RB;
					end else begin
						state_q <= ST_IDLE;
					end
				end
				ST_W_RB: begin
					state_q <= ST_W_RS;
				end
				ST_W_RS: begin
					state_q <= ST_W_EV;
				end
				ST_W_EV: begin
					if (out_free) begin
						if (keep) begin
							pend_v_q <= 1'b1;
						end
						// reach holds furthest latest position plus one
						if (slot_rd_q.first == idx_q[POS_W-1:0] && reach_cand > reach_q) begin
							reach_q <= reach_cand;
						end
						idx_q <= idx_q + CNT_W'(1);
						if (idx_q + CNT_W'(1) == fill_q) begin
							state_q <= ST_W_END;
						end else begin
							state_q <= ST_W_RB;
						end
					end
				end
				ST_W_END: begin
					if (out_free) begin
						if (final_q == pend_q) begin
							fill_q  <= '0;
							cut_q   <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_W_APP;
						end
					end
				end
				ST_W_APP: begin
					if (out_free) begin
						fill_q  <= '0;
						cut_q   <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept && fill_q != CNT_W'(MAX_LEN)) begin
			pos_q   <= fill_q[POS_W-1:0];
			slot_q  <= node[SLOT_W-1:0];
			final_q <= node;
		end else if (state_q == ST_W_RS) begin
			slot_q <= buf_rd_q[SLOT_W-1:0];
			node_q <= buf_rd_q;
		end
		if (state_q == ST_W_EV && out_free && keep) begin
			pend_q <= node_q;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_W'(MAX_LEN))
		else $error("fill count beyond buffer");

	a_reach_bound: assert property (@(posedge clk) disable iff (!arst_n)
		!(state_q == ST_IDLE || state_q == ST_LD_WR || state_q == ST_CLR) |->
		reach_q <= fill_q)
		else $error("reach beyond stored path");

	a_first_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_W_END) |-> pend_v_q)
		else $error("path closed with no kept node");

	a_no_push_loading: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE || state_q == ST_LD_WR || state_q == ST_CLR) |-> !push)
		else $error("result produced while loading");
endmodule
